[design/tbs_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the thrust body series step.
package tbs_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned MaxTermsDef = 30;
  localparam int unsigned RegW        = 31;
  localparam int unsigned CountW      = 5;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned InDataW     = 320;
  localparam int unsigned OutDataW    = 192;

  localparam logic [RegW-1:0]   MassRst   = 31'd65536;
  localparam logic [RegW-1:0]   RadiusRst = 31'd65536;
  localparam logic [CountW-1:0] TermsRst  = 5'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MASS   = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_TERMS  = 2'd2
  } cfg_idx_e;

  // lanes: coefficient words and Horner accumulators
  localparam logic [2:0] LaneA   = 3'd0;
  localparam logic [2:0] LaneB   = 3'd1;
  localparam logic [2:0] LaneVa  = 3'd2;
  localparam logic [2:0] LaneVb  = 3'd3;
  localparam logic [2:0] LanePa  = 3'd4;
  localparam logic [2:0] LanePb  = 3'd5;
  // lanes of the final scale products
  localparam logic [2:0] LaneTs  = 3'd0;
  localparam logic [2:0] LaneTt  = 3'd1;
  localparam logic [2:0] LaneTts = 3'd2;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_MUL_MR,
    OP_DIV_K,
    OP_K_SAVE,
    OP_DIV_S,
    OP_S_SAVE,
    OP_CO_INIT,
    OP_CO_MW,
    OP_CO_ACC_W,
    OP_CO_MK,
    OP_CO_ACC_K,
    OP_CO_SAVE,
    OP_QDIV,
    OP_QDIV_SAVE,
    OP_CO_WRITE,
    OP_H_CLEAR,
    OP_H_READ,
    OP_H_MUL,
    OP_H_ACC,
    OP_F_MUL,
    OP_F_SAVE,
    OP_SC_MUL,
    OP_SC_SAVE,
    OP_TV_MUL,
    OP_TV_SAVE,
    OP_F_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] lane;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  // last field in the lowest bits
  typedef struct packed {
    logic signed [DataW-1:0] ang_vel;
    logic signed [DataW-1:0] thrust_right;
    logic signed [DataW-1:0] thrust_left;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] vel_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] dir_y;
    logic signed [DataW-1:0] dir_x;
    logic signed [DataW-1:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] new_pos_y;
    logic signed [DataW-1:0] new_pos_x;
    logic signed [DataW-1:0] new_vel_y;
    logic signed [DataW-1:0] new_vel_x;
    logic signed [DataW-1:0] new_dir_y;
    logic signed [DataW-1:0] new_dir_x;
  } out_item_t;

  localparam logic signed [65:0] SatHi = 66'sd2147483647;
  localparam logic signed [65:0] SatLo = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SatHi) r = 32'sh7FFFFFFF;
    else if (x < SatLo) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    return sat32({{32{x[33]}}, x});
  endfunction

  // Q16.16 product: round to nearest, ties up, then saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [65:0] e;
    e = {{2{p[63]}}, p} + 66'sd32768;
    e = e >>> 16;
    return sat32(e);
  endfunction

endpackage

[design/tbs_div.sv]
// Shared restoring divider, one quotient bit per cycle, signed result saturated to 32 bits.
module tbs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        small_i,
  input  logic        neg_i,
  input  logic        floor_i,
  input  logic [63:0] dividend_i,
  input  logic [45:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic signed [31:0] quot_o
);
  import tbs_pkg::*;

  localparam logic [6:0] ItBig   = 7'd64;
  localparam logic [6:0] ItSmall = 7'd36;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] quo_q;
  logic [45:0] rem_q, dvs_q;
  logic        neg_q, floor_q;

  logic [46:0] rem_sh, diff;
  logic        ge;
  logic [45:0] rem_nx;
  logic        adj;
  logic [64:0] mag, negv;

  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? diff[45:0] : rem_sh[45:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= small_i ? ItSmall : ItBig;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q   <= small_i ? {dividend_i[35:0], 28'd0} : dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
      neg_q   <= neg_i;
      floor_q <= floor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= rem_nx;
    end
  end

  // apply sign; floor mode steps a negative inexact quotient down by one
  always_comb begin
    adj  = floor_q && (rem_q != '0);
    mag  = {1'b0, quo_q} + {64'd0, adj};
    negv = 65'd0 - mag;
    if (!neg_q) begin
      quot_o = (quo_q > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : quo_q[31:0];
    end else begin
      quot_o = (mag > 65'h8000_0000) ? 32'sh80000000 : negv[31:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[design/tbs_dp.sv]
// Datapath: shared multiplier, divider, coefficient memory and Horner accumulators.
module tbs_dp #(
  parameter int unsigned MAX_TERMS = tbs_pkg::MaxTermsDef,
  localparam int unsigned JW = $clog2(MAX_TERMS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tbs_pkg::in_item_t   in_item_i,
  input  logic [30:0]         mass_i,
  input  logic [30:0]         radius_i,
  input  tbs_pkg::cmd_t       cmd_i,
  input  logic [JW-1:0]       idx_i,
  output tbs_pkg::stat_t      stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output tbs_pkg::out_item_t  out_item_o
);
  import tbs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned MW = $clog2(MAX_TERMS * (MAX_TERMS + 1) + 1);

  in_item_t it_q;
  logic signed [31:0] k_q, s_q, ts_q, tts_q;
  logic signed [63:0] prod_q;
  logic signed [33:0] acc_q;
  logic signed [31:0] ca_q, cb_q;
  logic signed [31:0] qd_q [4];
  logic signed [31:0] va1_q, vb1_q, va2_q, vb2_q;
  logic signed [31:0] h_q [6];
  logic signed [31:0] tv_q [2];
  logic [5:0][31:0]   rd_q;
  logic [5:0][31:0]   mem_q [MAX_TERMS];
  out_item_t          out_q;
  logic               out_valid_q;

  logic signed [31:0] mul_a, mul_b, qm;
  logic               mul_en;
  logic signed [33:0] qm34;

  logic               div_go, div_small, div_neg, div_floor;
  logic [63:0]        div_dvd;
  logic [45:0]        div_dvs;
  logic               div_busy, div_done;
  logic signed [31:0] div_q;

  logic [33:0]        dk, dsum;
  logic [32:0]        dmag_k, dmag_s;
  logic [45:0]        mr;
  logic [MW-1:0]      m1, m2, msel;
  logic [31:0]        qx;
  logic [35:0]        num36, mag36;

  assign qm   = qround(prod_q);
  assign qm34 = sx34(qm);

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_MUL_MR: begin
        mul_a = {1'b0, mass_i};
        mul_b = {1'b0, radius_i};
      end
      OP_CO_MW: begin
        mul_a = (cmd_i.lane == LaneA) ? vb1_q : va1_q;
        mul_b = it_q.ang_vel;
      end
      OP_CO_MK: begin
        mul_a = (cmd_i.lane == LaneA) ? vb2_q : va2_q;
        mul_b = k_q;
      end
      OP_H_MUL: begin
        mul_a = h_q[cmd_i.lane];
        mul_b = it_q.step_time;
      end
      OP_F_MUL: begin
        mul_a = (cmd_i.lane == LaneTts) ? tts_q : it_q.step_time;
        mul_b = (cmd_i.lane == LaneTt) ? it_q.step_time : s_q;
      end
      OP_SC_MUL: begin
        mul_a = (cmd_i.lane < LanePa) ? ts_q : tts_q;
        mul_b = h_q[cmd_i.lane];
      end
      OP_TV_MUL: begin
        mul_a = it_q.step_time;
        mul_b = (cmd_i.lane == LaneA) ? it_q.vel_x : it_q.vel_y;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // divider operand select
  always_comb begin
    dk     = {{2{it_q.thrust_left[31]}}, it_q.thrust_left}
             - {{2{it_q.thrust_right[31]}}, it_q.thrust_right};
    dsum   = {{2{it_q.thrust_left[31]}}, it_q.thrust_left}
             + {{2{it_q.thrust_right[31]}}, it_q.thrust_right};
    dmag_k = dk[33] ? 33'(34'd0 - dk) : dk[32:0];
    dmag_s = dsum[33] ? 33'(34'd0 - dsum) : dsum[32:0];
    mr     = (prod_q[61:16] == '0) ? 46'd1 : prod_q[61:16];
    m1     = MW'(idx_i) + MW'(1);
    m2     = m1 * (m1 + MW'(1));
    msel   = cmd_i.lane[1] ? m2 : m1;
    qx     = cmd_i.lane[0] ? cb_q : ca_q;
    num36  = {{3{qx[31]}}, qx, 1'b0} + 36'(msel);
    mag36  = num36[35] ? (36'd0 - num36) : num36;
    div_go    = 1'b1;
    div_small = 1'b0;
    div_floor = 1'b0;
    div_neg   = 1'b0;
    div_dvd   = '0;
    div_dvs   = 46'd1;
    case (cmd_i.op)
      OP_DIV_K: begin
        div_neg = dk[33];
        div_dvd = {14'd0, dmag_k, 17'd0};
        div_dvs = mr;
      end
      OP_DIV_S: begin
        div_neg = dsum[33];
        div_dvd = {15'd0, dmag_s, 16'd0};
        div_dvs = (mass_i == '0) ? 46'd1 : {15'd0, mass_i};
      end
      OP_QDIV: begin
        div_small = 1'b1;
        div_floor = 1'b1;
        div_neg   = num36[35];
        div_dvd   = {28'd0, mag36};
        div_dvs   = 46'({msel, 1'b0});
      end
      default: div_go = 1'b0;
    endcase
  end

  tbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .small_i    (div_small),
    .neg_i      (div_neg),
    .floor_i    (div_floor),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (load_i) it_q <= in_item_i;
    if (mul_en) prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_K_SAVE:    k_q <= div_q;
      OP_S_SAVE:    s_q <= div_q;
      OP_CO_INIT: begin
        ca_q <= it_q.dir_x;
        cb_q <= it_q.dir_y;
      end
      OP_CO_ACC_W:  acc_q <= (cmd_i.lane == LaneA) ? (34'sd0 - qm34) : qm34;
      OP_CO_ACC_K:  acc_q <= (cmd_i.lane == LaneA) ? (acc_q - qm34) : (acc_q + qm34);
      OP_CO_SAVE: begin
        if (cmd_i.lane == LaneA) ca_q <= sat34(acc_q);
        else cb_q <= sat34(acc_q);
      end
      OP_QDIV_SAVE: qd_q[cmd_i.lane[1:0]] <= div_q;
      OP_CO_WRITE: begin
        va2_q <= va1_q;
        vb2_q <= vb1_q;
        va1_q <= qd_q[0];
        vb1_q <= qd_q[1];
      end
      OP_H_CLEAR: begin
        for (int c = 0; c < 6; c++) h_q[c] <= '0;
      end
      OP_H_ACC:   h_q[cmd_i.lane] <= sat34(qm34 + sx34(rd_q[cmd_i.lane]));
      OP_F_SAVE: begin
        if (cmd_i.lane == LaneTs) ts_q <= qm;
        else tts_q <= qm;
      end
      OP_SC_SAVE: h_q[cmd_i.lane] <= qm;
      OP_TV_SAVE: tv_q[cmd_i.lane[0]] <= sat34(qm34 + sx34((cmd_i.lane == LaneA) ?
                                                           it_q.pos_x : it_q.pos_y));
      OP_F_OUT: begin
        out_q.new_dir_x <= h_q[LaneA];
        out_q.new_dir_y <= h_q[LaneB];
        out_q.new_vel_x <= sat34(sx34(it_q.vel_x) + sx34(h_q[LaneVa]));
        out_q.new_vel_y <= sat34(sx34(it_q.vel_y) + sx34(h_q[LaneVb]));
        out_q.new_pos_x <= sat34(sx34(tv_q[0]) + sx34(h_q[LanePa]));
        out_q.new_pos_y <= sat34(sx34(tv_q[1]) + sx34(h_q[LanePb]));
      end
      default: ;
    endcase
  end

  // coefficient memory: one write per term, one registered read per Horner step
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CO_WRITE) begin
      mem_q[idx_i[AW-1:0]] <= {qd_q[3], qd_q[2], qd_q[1], qd_q[0], cb_q, ca_q};
    end
    if (cmd_i.op == OP_H_READ) begin
      rd_q <= mem_q[idx_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_F_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

`ifndef SYNTH
  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_F_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result pushed over an untaken result");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go |-> !div_busy)
    else $error("divider restarted while busy");
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == OP_H_READ) || (cmd_i.op == OP_CO_WRITE)) |-> (32'(idx_i) < 32'(MAX_TERMS)))
    else $error("coefficient index out of range");
`endif

endmodule

[design/tbs_ctrl.sv]
// Controller: sequences setup divides, coefficient recurrence, Horner passes and final scaling.
module tbs_ctrl #(
  parameter int unsigned MAX_TERMS = tbs_pkg::MaxTermsDef,
  localparam int unsigned JW = $clog2(MAX_TERMS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tbs_pkg::CountW-1:0]  term_count_i,
  input  tbs_pkg::stat_t              stat_i,
  output tbs_pkg::cmd_t               cmd_o,
  output logic [JW-1:0]               idx_o
);
  import tbs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MR, ST_DK_GO, ST_DK_WAIT, ST_DS_GO, ST_DS_WAIT,
    ST_CO_CHK, ST_CO_MW, ST_CO_AW, ST_CO_MK, ST_CO_AK, ST_CO_SV,
    ST_QD_GO, ST_QD_WAIT, ST_CO_WR,
    ST_H_INIT, ST_H_RD, ST_H_MUL, ST_H_ACC,
    ST_F_MUL, ST_F_SAVE, ST_SC_MUL, ST_SC_SAVE, ST_TV_MUL, ST_TV_SAVE, ST_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [JW-1:0] j_q, j_d, n_q, n_d;
  logic [2:0]    lane_q, lane_d;

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    n_d        = n_q;
    lane_d     = lane_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.lane = lane_q;
    idx_o      = j_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d     = (32'(term_count_i) > 32'(MAX_TERMS)) ? JW'(MAX_TERMS) : JW'(term_count_i);
          j_d     = '0;
          lane_d  = LaneA;
          state_d = ST_MR;
        end
      end
      ST_MR: begin
        cmd_o.op = OP_MUL_MR;
        state_d  = ST_DK_GO;
      end
      ST_DK_GO: begin
        cmd_o.op = OP_DIV_K;
        state_d  = ST_DK_WAIT;
      end
      ST_DK_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_K_SAVE;
          state_d  = ST_DS_GO;
        end
      end
      ST_DS_GO: begin
        cmd_o.op = OP_DIV_S;
        state_d  = ST_DS_WAIT;
      end
      ST_DS_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_S_SAVE;
          state_d  = ST_CO_CHK;
        end
      end
      ST_CO_CHK: begin
        lane_d = LaneA;
        if (j_q == n_q) begin
          state_d = ST_H_INIT;
        end else if (j_q == '0) begin
          cmd_o.op = OP_CO_INIT;
          state_d  = ST_QD_GO;
        end else begin
          state_d = ST_CO_MW;
        end
      end
      ST_CO_MW: begin
        cmd_o.op = OP_CO_MW;
        state_d  = ST_CO_AW;
      end
      ST_CO_AW: begin
        cmd_o.op = OP_CO_ACC_W;
        state_d  = (j_q > JW'(1)) ? ST_CO_MK : ST_CO_SV;
      end
      ST_CO_MK: begin
        cmd_o.op = OP_CO_MK;
        state_d  = ST_CO_AK;
      end
      ST_CO_AK: begin
        cmd_o.op = OP_CO_ACC_K;
        state_d  = ST_CO_SV;
      end
      ST_CO_SV: begin
        cmd_o.op = OP_CO_SAVE;
        if (lane_q == LaneA) begin
          lane_d  = LaneB;
          state_d = ST_CO_MW;
        end else begin
          lane_d  = LaneA;
          state_d = ST_QD_GO;
        end
      end
      ST_QD_GO: begin
        cmd_o.op = OP_QDIV;
        state_d  = ST_QD_WAIT;
      end
      ST_QD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_QDIV_SAVE;
          if (lane_q == LaneVb) begin
            lane_d  = LaneA;
            state_d = ST_CO_WR;
          end else begin
            lane_d  = lane_q + 3'd1;
            state_d = ST_QD_GO;
          end
        end
      end
      ST_CO_WR: begin
        cmd_o.op = OP_CO_WRITE;
        j_d      = j_q + JW'(1);
        state_d  = ST_CO_CHK;
      end
      ST_H_INIT: begin
        cmd_o.op = OP_H_CLEAR;
        lane_d   = LaneA;
        state_d  = (j_q == '0) ? ST_F_MUL : ST_H_RD;
      end
      ST_H_RD: begin
        cmd_o.op = OP_H_READ;
        idx_o    = j_q - JW'(1);
        j_d      = j_q - JW'(1);
        lane_d   = LaneA;
        state_d  = ST_H_MUL;
      end
      ST_H_MUL: begin
        cmd_o.op = OP_H_MUL;
        state_d  = ST_H_ACC;
      end
      ST_H_ACC: begin
        cmd_o.op = OP_H_ACC;
        if (lane_q == LanePb) begin
          lane_d  = LaneTs;
          state_d = (j_q == '0) ? ST_F_MUL : ST_H_RD;
        end else begin
          lane_d  = lane_q + 3'd1;
          state_d = ST_H_MUL;
        end
      end
      ST_F_MUL: begin
        cmd_o.op = OP_F_MUL;
        state_d  = ST_F_SAVE;
      end
      ST_F_SAVE: begin
        cmd_o.op = OP_F_SAVE;
        if (lane_q == LaneTts) begin
          lane_d  = LaneVa;
          state_d = ST_SC_MUL;
        end else begin
          lane_d  = lane_q + 3'd1;
          state_d = ST_F_MUL;
        end
      end
      ST_SC_MUL: begin
        cmd_o.op = OP_SC_MUL;
        state_d  = ST_SC_SAVE;
      end
      ST_SC_SAVE: begin
        cmd_o.op = OP_SC_SAVE;
        if (lane_q == LanePb) begin
          lane_d  = LaneA;
          state_d = ST_TV_MUL;
        end else begin
          lane_d  = lane_q + 3'd1;
          state_d = ST_SC_MUL;
        end
      end
      ST_TV_MUL: begin
        cmd_o.op = OP_TV_MUL;
        state_d  = ST_TV_SAVE;
      end
      ST_TV_SAVE: begin
        cmd_o.op = OP_TV_SAVE;
        if (lane_q == LaneB) begin
          lane_d  = LaneA;
          state_d = ST_OUT;
        end else begin
          lane_d  = LaneB;
          state_d = ST_TV_MUL;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_F_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      n_q     <= '0;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      n_q     <= n_d;
      lane_q  <= lane_d;
    end
  end

endmodule

[design/thrust_body_series_step.sv]
// Top level of the thrust body series step: configuration registers and stream ports.
//
// Advances a two-thruster body over one time step by a truncated power series in
// Q16.16. The slave stream carries one transaction per body state (step time,
// direction, velocity, position, thrusts, angular rate); the master stream returns
// one transaction with the new direction, velocity and position.
// Configuration: write body_mass, body_radius or term_count through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; writes take effect at once.
// The run time of an item is set by the shared bit-serial divider: two 64-step
// divides for the thrust ratios and four 36-step divides per term for the integrated
// series coefficients. The Horner passes run on the single shared 32x32 multiplier.
// One item is in work at a time; s_axis_tready is high only while the block waits for
// a new item. A finished result sits in the output register, so the next item is
// accepted while that result still waits for m_axis_tready; if the receiver stalls
// longer, the following result holds in the sequencer until the slot frees. Reset
// restores the register defaults (mass 1.0, radius 1.0, seven terms) and drops any
// item in work and any result not yet taken.
module thrust_body_series_step_core #(
  parameter int unsigned MAX_TERMS = tbs_pkg::MaxTermsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // step_time, dir_x, dir_y, vel_x, vel_y, pos_x, pos_y, thrust_left,
  // thrust_right, ang_vel (32 bits each, from bit 0 up)
  input  logic [tbs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_dir_x, new_dir_y, new_vel_x, new_vel_y, new_pos_x, new_pos_y
  // (32 bits each, from bit 0 up)
  output logic [tbs_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [tbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbs_pkg::RegW-1:0]      cfg_data_i
);
  import tbs_pkg::*;

  localparam int unsigned JW = $clog2(MAX_TERMS + 1);

  logic [RegW-1:0]   mass_q, radius_q;
  logic [CountW-1:0] terms_q;

  cmd_t          cmd;
  stat_t         stat;
  logic [JW-1:0] idx;
  logic          accept;
  in_item_t      in_item;
  out_item_t     out_item;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q   <= MassRst;
      radius_q <= RadiusRst;
      terms_q  <= TermsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASS:   mass_q   <= cfg_data_i;
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_TERMS:  terms_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_item = s_axis_tdata;

  tbs_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .term_count_i (terms_q),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .idx_o        (idx)
  );

  tbs_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .in_item_i   (in_item),
    .mass_i      (mass_q),
    .radius_i    (radius_q),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = out_item;

endmodule
